@@ rtl/ppl_pkg.sv @@
`default_nettype none
package ppl_pkg;

    localparam int OP_W   = 3;
    localparam int CFG_W  = 24;
    localparam int LC_W   = 16;
    localparam int TS_W   = 16;
    localparam int MODE_W = 3;
    localparam int IDX_W  = 3;
    localparam int KIND_W = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_START   = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd2;
    localparam logic [OP_W-1:0] OP_PAUSE   = 3'd3;
    localparam logic [OP_W-1:0] OP_UNPAUSE = 3'd4;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd5;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_YOYO  = 2'd3;

    localparam logic [IDX_W-1:0] REG_DURATION    = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_DELAY = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOOP_DELAY  = 3'd2;
    localparam logic [IDX_W-1:0] REG_YOYO_DELAY  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LOOP_COUNT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_TIME_SCALE  = 3'd5;
    localparam logic [IDX_W-1:0] REG_YOYO_ENABLE = 3'd6;
    localparam logic [IDX_W-1:0] REG_MODE_FLAGS  = 3'd7;

    localparam int MODE_FREE_RUN = 0;
    localparam int MODE_DILATED  = 1;
    localparam int MODE_STOP     = 2;

    typedef struct packed {
        logic moved;
        logic loop_ev;
        logic yoyo_ev;
        logic done_ev;
    } t_evt;

endpackage
`default_nettype wire

@@ rtl/ppl_in_if.sv @@
`default_nettype none
interface ppl_in_if #(
    parameter int DELTA_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic [ppl_pkg::OP_W-1:0]    op;
    logic [DELTA_BITS-1:0]       raw_delta;
    logic [DELTA_BITS-1:0]       dilated_delta;
    logic                        global_pause;

    modport source (output valid, op, raw_delta, dilated_delta, global_pause, input ready);
    modport sink   (input valid, op, raw_delta, dilated_delta, global_pause, output ready);
endinterface
`default_nettype wire

@@ rtl/ppl_out_if.sv @@
`default_nettype none
interface ppl_out_if #(
    parameter int TIME_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] position;
    logic                 going_back;
    logic                 running;
    logic                 held;
    logic                 moved;
    logic                 loop_event;
    logic                 yoyo_event;
    logic                 done_event;

    modport source (output valid, position, going_back, running, held, moved, loop_event,
                    yoyo_event, done_event, input ready);
    modport sink   (input valid, position, going_back, running, held, moved, loop_event,
                    yoyo_event, done_event, output ready);
endinterface
`default_nettype wire

@@ rtl/ppl_scale.sv @@
`default_nettype none
module ppl_scale #(
    parameter int DELTA_BITS = 16
) (
    input  wire logic [DELTA_BITS-1:0]      i_raw_delta,
    input  wire logic [DELTA_BITS-1:0]      i_dilated_delta,
    input  wire logic                       i_use_dilated,
    input  wire logic [ppl_pkg::TS_W-1:0]   i_time_scale,
    output logic      [DELTA_BITS+7:0]      o_scaled
);
    localparam int PROD_W = DELTA_BITS + ppl_pkg::TS_W;

    logic [DELTA_BITS-1:0] delta;
    logic [PROD_W-1:0]     prod;

    assign delta    = i_use_dilated ? i_dilated_delta : i_raw_delta;
    // Q8.8 scale, fraction dropped
    assign prod     = PROD_W'(delta) * PROD_W'(i_time_scale);
    assign o_scaled = prod[PROD_W-1:8];
endmodule
`default_nettype wire

@@ rtl/pingpong_loop_timeline_top.sv @@
`default_nettype none
// An accepted input beat is registered in stage 1, then its result beat in the result register.
// Throughput: one item per cycle unless the output stalls; stage 1 registers the input and the scaled
// delta (one multiplier), stage 2 updates the timeline state into the result register.
// An output stall holds both stages; input ready follows from it.
// Reset (sync, active low) clears state and valids and loads the register defaults.
module pingpong_loop_timeline_top #(
    parameter int TIME_BITS  = 24,
    parameter int DELTA_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ppl_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ppl_pkg::CFG_W-1:0]     i_cfg_data,
    ppl_in_if.sink                             i_in,
    ppl_out_if.source                          o_out
);
    localparam int CW  = ppl_pkg::CFG_W;
    localparam int SW  = DELTA_BITS + 8;
    localparam int M1  = (TIME_BITS > SW) ? TIME_BITS : SW;
    localparam int M2  = (M1 > CW) ? M1 : CW;
    localparam int PW  = M2 + 1;
    localparam int LCW = ppl_pkg::LC_W;

    // configuration
    logic [CW-1:0]                 r_dur, r_sdly, r_ldly, r_ydly;
    logic [LCW-1:0]                r_lc;
    logic [ppl_pkg::TS_W-1:0]      r_ts;
    logic                          r_yoyo;
    logic [ppl_pkg::MODE_W-1:0]    r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur  <= CW'(1000);
            r_sdly <= '0;
            r_ldly <= '0;
            r_ydly <= '0;
            r_lc   <= LCW'(1);
            r_ts   <= ppl_pkg::TS_W'(256);
            r_yoyo <= 1'b0;
            r_mode <= ppl_pkg::MODE_W'(6);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppl_pkg::REG_DURATION:    r_dur  <= i_cfg_data;
                ppl_pkg::REG_START_DELAY: r_sdly <= i_cfg_data;
                ppl_pkg::REG_LOOP_DELAY:  r_ldly <= i_cfg_data;
                ppl_pkg::REG_YOYO_DELAY:  r_ydly <= i_cfg_data;
                ppl_pkg::REG_LOOP_COUNT:  r_lc   <= i_cfg_data[LCW-1:0];
                ppl_pkg::REG_TIME_SCALE:  r_ts   <= i_cfg_data[ppl_pkg::TS_W-1:0];
                ppl_pkg::REG_YOYO_ENABLE: r_yoyo <= i_cfg_data[0];
                ppl_pkg::REG_MODE_FLAGS:  r_mode <= i_cfg_data[ppl_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic r_s1v, r_ov;
    logic adv, in_rdy;

    assign adv    = !r_ov || o_out.ready;
    assign in_rdy = !r_s1v || adv;
    assign i_in.ready = in_rdy;

    // stage 1
    logic [SW-1:0]              scaled;
    logic [SW-1:0]              r_s1_scaled;
    logic [ppl_pkg::OP_W-1:0]   r_s1_op;
    logic                       r_s1_gp;

    ppl_scale #(.DELTA_BITS(DELTA_BITS)) u_scale (
        .i_raw_delta     (i_in.raw_delta),
        .i_dilated_delta (i_in.dilated_delta),
        .i_use_dilated   (r_mode[ppl_pkg::MODE_DILATED]),
        .i_time_scale    (r_ts),
        .o_scaled        (scaled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (in_rdy) begin
            r_s1v <= i_in.valid;
        end
        if (in_rdy && i_in.valid) begin
            r_s1_scaled <= scaled;
            r_s1_op     <= i_in.op;
            r_s1_gp     <= i_in.global_pause;
        end
    end

    // stage 2: timeline state
    logic [TIME_BITS-1:0]         r_pos, n_pos;
    logic [CW-1:0]                r_wait, n_wait;
    logic [ppl_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic                         r_back, n_back;
    logic [LCW-1:0]               r_lf, n_lf;
    logic                         r_alive, n_alive;
    logic                         r_hold, n_hold;
    ppl_pkg::t_evt                n_evt;

    always_comb begin
        logic [CW-1:0]  dur;
        logic [PW-1:0]  scl_x, wait_x, pos_x, dur_x, p, pos_chk;
        logic           fin;
        logic           ticking;
        logic [LCW-1:0] lf_new;

        n_pos   = r_pos;
        n_wait  = r_wait;
        n_kind  = r_kind;
        n_back  = r_back;
        n_lf    = r_lf;
        n_alive = r_alive;
        n_hold  = r_hold;
        n_evt   = '0;

        dur     = (r_dur == '0) ? CW'(1) : r_dur;
        scl_x   = PW'(r_s1_scaled);
        wait_x  = PW'(r_wait);
        pos_x   = PW'(r_pos);
        dur_x   = PW'(dur);
        p       = '0;
        pos_chk = '0;
        fin     = 1'b0;
        lf_new  = (r_lf != '1) ? r_lf + LCW'(1) : r_lf;
        ticking = r_alive && !r_hold && !(r_s1_gp && !r_mode[ppl_pkg::MODE_FREE_RUN]);

        unique case (r_s1_op) inside
            ppl_pkg::OP_TICK: begin
                if (ticking) begin
                    if (r_wait != '0) begin
                        if (scl_x >= wait_x) begin
                            n_wait = '0;
                            if (r_kind == ppl_pkg::KIND_LOOP) n_evt.loop_ev = 1'b1;
                            else if (r_kind == ppl_pkg::KIND_YOYO) n_evt.yoyo_ev = 1'b1;
                        end else begin
                            n_wait = r_wait - r_s1_scaled[CW-1:0];
                        end
                    end else begin
                        if (r_back) p = (scl_x >= pos_x) ? '0 : pos_x - scl_x;
                        else p = pos_x + scl_x;
                        if (p > dur_x) p = dur_x;
                        n_pos = p[TIME_BITS-1:0];
                        n_evt.moved = 1'b1;
                        pos_chk = PW'(n_pos);
                        if (r_back) begin
                            fin = (pos_chk == '0);
                        end else if (pos_chk >= dur_x) begin
                            if (r_yoyo) begin
                                n_back = 1'b1;
                                n_wait = r_ydly;
                                if (r_ydly != '0) n_kind = ppl_pkg::KIND_YOYO;
                                else n_evt.yoyo_ev = 1'b1;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        if (fin) begin
                            n_lf = lf_new;
                            if (r_lc[LCW-1] || lf_new < r_lc) begin
                                n_wait = r_ldly;
                                n_pos  = '0;
                                n_back = 1'b0;
                                if (r_ldly != '0) n_kind = ppl_pkg::KIND_LOOP;
                                else n_evt.loop_ev = 1'b1;
                            end else begin
                                n_evt.done_ev = 1'b1;
                                if (r_mode[ppl_pkg::MODE_STOP]) n_alive = 1'b0;
                                else n_hold = 1'b1;
                            end
                        end
                    end
                end
            end
            ppl_pkg::OP_START, ppl_pkg::OP_RESTART: begin
                if (r_s1_op == ppl_pkg::OP_START || r_alive) begin
                    n_alive = 1'b1;
                    n_pos   = '0;
                    n_back  = 1'b0;
                    n_lf    = '0;
                    n_hold  = 1'b0;
                    n_wait  = r_sdly;
                    n_kind  = (r_sdly != '0) ? ppl_pkg::KIND_START : ppl_pkg::KIND_NONE;
                end
            end
            ppl_pkg::OP_PAUSE:   n_hold  = 1'b1;
            ppl_pkg::OP_UNPAUSE: n_hold  = 1'b0;
            ppl_pkg::OP_STOP:    n_alive = 1'b0;
            default: ;
        endcase
    end

    logic [TIME_BITS-1:0] r_o_pos;
    logic                 r_o_back, r_o_run, r_o_hold;
    ppl_pkg::t_evt        r_o_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_pos   <= '0;
            r_wait  <= '0;
            r_kind  <= ppl_pkg::KIND_NONE;
            r_back  <= 1'b0;
            r_lf    <= '0;
            r_alive <= 1'b0;
            r_hold  <= 1'b0;
        end else if (adv) begin
            r_ov <= r_s1v;
            if (r_s1v) begin
                r_pos   <= n_pos;
                r_wait  <= n_wait;
                r_kind  <= n_kind;
                r_back  <= n_back;
                r_lf    <= n_lf;
                r_alive <= n_alive;
                r_hold  <= n_hold;
            end
        end
        if (adv && r_s1v) begin
            r_o_pos  <= n_pos;
            r_o_back <= n_back;
            r_o_run  <= n_alive;
            r_o_hold <= n_hold;
            r_o_evt  <= n_evt;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.position   = r_o_pos;
    assign o_out.going_back = r_o_back;
    assign o_out.running    = r_o_run;
    assign o_out.held       = r_o_hold;
    assign o_out.moved      = r_o_evt.moved;
    assign o_out.loop_event = r_o_evt.loop_ev;
    assign o_out.yoyo_event = r_o_evt.yoyo_ev;
    assign o_out.done_event = r_o_evt.done_ev;

    a_evt_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> $onehot0({r_o_evt.loop_ev, r_o_evt.yoyo_ev, r_o_evt.done_ev}))
        else $error("more than one timeline event in a beat");

    a_wait_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait != '0) |-> (r_kind != ppl_pkg::KIND_NONE))
        else $error("pending delay without a kind");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_evt.done_ev) |-> (!r_o_run || r_o_hold))
        else $error("completion left the timeline running");

    a_moved_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1v && adv && n_evt.moved) |-> (r_wait == '0))
        else $error("position moved while a delay was pending");

endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ppl_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [ppl_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_PHASES   = 11;
    localparam int PHASE_ITEMS = 78;

    typedef struct packed {
        logic [ppl_pkg::OP_W-1:0] op;
        logic [15:0]              raw;
        logic [15:0]              dil;
        logic                     gpause;
    } t_cmd_beat;

    typedef struct packed {
        logic [23:0] position;
        logic        going_back;
        logic        running;
        logic        held;
        logic        moved;
        logic        loop_event;
        logic        yoyo_event;
        logic        done_event;
    } t_tl_status;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_we = 1'b0;
    logic [ppl_pkg::IDX_W-1:0]  cfg_idx = '0;
    logic [ppl_pkg::CFG_W-1:0]  cfg_data = '0;

    logic                       in_vld = 1'b0;
    logic [ppl_pkg::OP_W-1:0]   in_op = ppl_pkg::OP_TICK;
    logic [15:0]                in_raw = '0;
    logic [15:0]                in_dil = '0;
    logic                       in_gp = 1'b0;
    logic                       out_rdy = 1'b0;

    ppl_in_if  #(.DELTA_BITS(16)) in_if();
    ppl_out_if #(.TIME_BITS(24))  out_if();

    assign in_if.valid         = in_vld;
    assign in_if.op            = in_op;
    assign in_if.raw_delta     = in_raw;
    assign in_if.dilated_delta = in_dil;
    assign in_if.global_pause  = in_gp;
    assign out_if.ready        = out_rdy;

    pingpong_loop_timeline_top #(
        .TIME_BITS (24),
        .DELTA_BITS(16)
    ) u_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_if),
        .o_out     (out_if)
    );

    // register settings, one row per phase; row 0 is the directed part
    int phase_tbl [N_PHASES][8] = '{
        '{10,       3,        2,        2,        2,      256,   1, 6},
        '{1000,     0,        0,        0,        1,      256,   0, 6},
        '{50,       0,        0,        0,        3,      256,   0, 2},
        '{1,        5,        1,        1,        -1,     256,   1, 0},
        '{0,        0,        3,        0,        2,      1,     1, 4},
        '{16777215, 16777215, 16777215, 16777215, 32767,  65535, 1, 1},
        '{200,      30,       20,       15,       4,      384,   1, 3},
        '{100,      0,        0,        0,        0,      128,   0, 2},
        '{30,       2,        3,        4,        -32768, 1,     1, 5},
        '{17,       0,        0,        0,        2,      0,     1, 7},
        '{300,      1,        1,        1,        5,      65535, 1, 7}
    };

    // timeline model state and register copy
    logic [23:0]        cfg_dur = 24'd1000;
    logic [23:0]        cfg_sdl = '0;
    logic [23:0]        cfg_ldl = '0;
    logic [23:0]        cfg_ydl = '0;
    logic signed [15:0] cfg_loops = 16'sd1;
    logic [15:0]        cfg_scale = 16'd256;
    logic               cfg_yoyo = 1'b0;
    logic [2:0]         cfg_mode = 3'd6;

    logic [23:0]                  tl_pos = '0;
    logic [25:0]                  tl_wait = '0;
    logic [ppl_pkg::KIND_W-1:0]   tl_kind = ppl_pkg::KIND_NONE;
    logic                         tl_back = 1'b0;
    logic [15:0]                  tl_loops = '0;
    logic                         tl_alive = 1'b0;
    logic                         tl_hold = 1'b0;
    logic                         ev_loop, ev_yoyo, ev_done;

    t_cmd_beat  pending_cmds [$];
    t_tl_status expected_status [$];

    int errs = 0;
    int n_in = 0, n_out = 0, n_loop = 0, n_yoyo = 0, n_done = 0, n_moved = 0;
    int idle_cyc = 0;
    int rcv_cyc = 0;
    int burst_left = 8, gap_left = 0;
    t_cmd_beat  drv_beat;
    t_tl_status pred, want, got;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic begin_timeline();
        tl_pos   = '0;
        tl_back  = 1'b0;
        tl_loops = '0;
        tl_hold  = 1'b0;
        tl_wait  = 26'(cfg_sdl);
        tl_kind  = (cfg_sdl != 0) ? ppl_pkg::KIND_START : ppl_pkg::KIND_NONE;
    endtask

    task automatic next_loop();
        tl_wait = 26'(cfg_ldl);
        tl_pos  = '0;
        tl_back = 1'b0;
        if (tl_wait != 0) tl_kind = ppl_pkg::KIND_LOOP;
        else ev_loop = 1'b1;
    endtask

    task automatic finish_pass();
        if (tl_loops != 16'hFFFF) tl_loops = tl_loops + 16'd1;
        if (cfg_loops < 0 || int'(tl_loops) < int'(cfg_loops)) begin
            next_loop();
        end else begin
            ev_done = 1'b1;
            if (cfg_mode[ppl_pkg::MODE_STOP]) tl_alive = 1'b0;
            else tl_hold = 1'b1;
        end
    endtask

    task automatic step_timeline(input t_cmd_beat b, output t_tl_status r);
        logic [15:0] d;
        logic [31:0] scaled;
        logic [31:0] dur;
        logic [31:0] p;
        logic        moved;
        moved   = 1'b0;
        ev_loop = 1'b0;
        ev_yoyo = 1'b0;
        ev_done = 1'b0;
        case (b.op)
            ppl_pkg::OP_TICK: begin
                if (tl_alive && !tl_hold &&
                    !(b.gpause && !cfg_mode[ppl_pkg::MODE_FREE_RUN])) begin
                    d      = cfg_mode[ppl_pkg::MODE_DILATED] ? b.dil : b.raw;
                    scaled = (32'(d) * 32'(cfg_scale)) >> 8;
                    dur    = (cfg_dur == 0) ? 32'd1 : 32'(cfg_dur);
                    if (tl_wait != 0) begin
                        if (scaled >= 32'(tl_wait)) begin
                            tl_wait = '0;
                            if (tl_kind == ppl_pkg::KIND_LOOP) ev_loop = 1'b1;
                            else if (tl_kind == ppl_pkg::KIND_YOYO) ev_yoyo = 1'b1;
                        end else begin
                            tl_wait = tl_wait - 26'(scaled);
                        end
                    end else begin
                        p = 32'(tl_pos);
                        if (tl_back) p = (scaled >= p) ? 32'd0 : p - scaled;
                        else p = p + scaled;
                        if (p > dur) p = dur;
                        tl_pos = p[23:0];
                        moved  = 1'b1;
                        if (tl_back) begin
                            if (tl_pos == 0) finish_pass();
                        end else if (32'(tl_pos) >= dur) begin
                            if (cfg_yoyo) begin
                                tl_back = 1'b1;
                                tl_wait = 26'(cfg_ydl);
                                if (tl_wait != 0) tl_kind = ppl_pkg::KIND_YOYO;
                                else ev_yoyo = 1'b1;
                            end else begin
                                finish_pass();
                            end
                        end
                    end
                end
            end
            ppl_pkg::OP_START: begin
                tl_alive = 1'b1;
                begin_timeline();
            end
            ppl_pkg::OP_RESTART: if (tl_alive) begin_timeline();
            ppl_pkg::OP_PAUSE:   tl_hold = 1'b1;
            ppl_pkg::OP_UNPAUSE: tl_hold = 1'b0;
            ppl_pkg::OP_STOP:    tl_alive = 1'b0;
            default: ;
        endcase
        r.position   = tl_pos;
        r.going_back = tl_back;
        r.running    = tl_alive;
        r.held       = tl_hold;
        r.moved      = moved;
        r.loop_event = ev_loop;
        r.yoyo_event = ev_yoyo;
        r.done_event = ev_done;
    endtask

    function automatic t_cmd_beat mk_cmd(logic [ppl_pkg::OP_W-1:0] op);
        t_cmd_beat b;
        b.op     = op;
        b.raw    = 16'($urandom);
        b.dil    = 16'($urandom);
        b.gpause = 1'($urandom);
        return b;
    endfunction

    function automatic t_cmd_beat mk_tick(logic [15:0] d, logic gp);
        t_cmd_beat b;
        b = mk_cmd(ppl_pkg::OP_TICK);
        if (cfg_mode[ppl_pkg::MODE_DILATED]) b.dil = d;
        else b.raw = d;
        b.gpause = gp;
        return b;
    endfunction

    // delta mostly sized so that a pass takes a handful of ticks; else zero, all ones or random
    function automatic logic [15:0] pick_delta();
        int unsigned sel;
        longint unsigned want_ticks;
        longint unsigned dv;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'h0000;
        if (sel == 1) return 16'hFFFF;
        if (sel == 2 || cfg_scale == 0) return 16'($urandom);
        want_ticks = longint'((cfg_dur == 0) ? 1 : cfg_dur) / $urandom_range(1, 8)
                     + $urandom_range(0, 2);
        dv = (want_ticks * 256) / cfg_scale;
        return (dv > 65535) ? 16'hFFFF : dv[15:0];
    endfunction

    function automatic logic [ppl_pkg::OP_W-1:0] ctl_op();
        case ($urandom_range(0, 7)) inside
            0: return ppl_pkg::OP_PAUSE;
            1, 2: return ppl_pkg::OP_UNPAUSE;
            3: return ppl_pkg::OP_STOP;
            4: return ppl_pkg::OP_RESTART;
            5: return ppl_pkg::OP_START;
            6: return OP_RSVD6;
            default: return OP_RSVD7;
        endcase
    endfunction

    task automatic write_reg(logic [ppl_pkg::IDX_W-1:0] idx, int val);
        logic [ppl_pkg::CFG_W-1:0] data;
        case (idx) inside
            ppl_pkg::REG_LOOP_COUNT, ppl_pkg::REG_TIME_SCALE:
                data = {8'($urandom), 16'(val)};
            ppl_pkg::REG_YOYO_ENABLE: data = {23'($urandom), 1'(val)};
            ppl_pkg::REG_MODE_FLAGS:  data = {21'($urandom), 3'(val)};
            default:                  data = 24'(val);
        endcase
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            ppl_pkg::REG_DURATION:    cfg_dur   = data;
            ppl_pkg::REG_START_DELAY: cfg_sdl   = data;
            ppl_pkg::REG_LOOP_DELAY:  cfg_ldl   = data;
            ppl_pkg::REG_YOYO_DELAY:  cfg_ydl   = data;
            ppl_pkg::REG_LOOP_COUNT:  cfg_loops = data[15:0];
            ppl_pkg::REG_TIME_SCALE:  cfg_scale = data[15:0];
            ppl_pkg::REG_YOYO_ENABLE: cfg_yoyo  = data[0];
            default:                  cfg_mode  = data[2:0];
        endcase
    endtask

    task automatic load_phase(int row);
        for (int r = 0; r < 8; r++) write_reg(ppl_pkg::IDX_W'(r), phase_tbl[row][r]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_cmds.size() != 0 || in_vld || expected_status.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_random(int n);
        int cnt;
        int len;
        cnt = 0;
        while (cnt < n) begin
            pending_cmds.push_back(mk_cmd(($urandom_range(0, 7) == 0) ?
                                          ppl_pkg::OP_RESTART : ppl_pkg::OP_START));
            len = $urandom_range(4, 30);
            if (len > n - cnt - 1) len = n - cnt - 1;
            repeat (len) begin
                if ($urandom_range(0, 99) < 7) pending_cmds.push_back(mk_cmd(ctl_op()));
                else pending_cmds.push_back(mk_tick(pick_delta(), $urandom_range(0, 7) == 0));
            end
            cnt += len + 1;
        end
    endtask

    task automatic check_field(string fld, logic [23:0] e, logic [23:0] a);
        if (e !== a) begin
            errs++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fld, e, a);
        end
    endtask

    // beat source
    always @(posedge clk) begin
        if (!rst_n) begin
            in_vld <= 1'b0;
        end else begin
            if (in_vld && in_if.ready) begin
                step_timeline({in_op, in_raw, in_dil, in_gp}, pred);
                expected_status.push_back(pred);
                n_in++;
            end
            if (!in_vld || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_vld <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    drv_beat = pending_cmds.pop_front();
                    in_op  <= drv_beat.op;
                    in_raw <= drv_beat.raw;
                    in_dil <= drv_beat.dil;
                    in_gp  <= drv_beat.gpause;
                    in_vld <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_vld <= 1'b0;
                end
            end
        end
    end

    // result sink, stall pattern and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            rcv_cyc++;
            case ((rcv_cyc / 97) % 4)
                0: out_rdy <= 1'b1;
                1: out_rdy <= 1'($urandom);
                2: out_rdy <= ($urandom_range(0, 3) == 0);
                default: out_rdy <= ((rcv_cyc % 23) < 3);
            endcase
            if (out_if.valid && out_rdy) begin
                got = {out_if.position, out_if.going_back, out_if.running, out_if.held,
                       out_if.moved, out_if.loop_event, out_if.yoyo_event, out_if.done_event};
                n_out++;
                if (expected_status.size() == 0) begin
                    errs++;
                    $display("%0t: result beat with none expected, expected none actual %0h",
                             $time, got);
                end else begin
                    want = expected_status.pop_front();
                    check_field("position",   want.position,   got.position);
                    check_field("going_back", want.going_back, got.going_back);
                    check_field("running",    want.running,    got.running);
                    check_field("held",       want.held,       got.held);
                    check_field("moved",      want.moved,      got.moved);
                    check_field("loop_event", want.loop_event, got.loop_event);
                    check_field("yoyo_event", want.yoyo_event, got.yoyo_event);
                    check_field("done_event", want.done_event, got.done_event);
                    n_moved += want.moved;
                    n_loop  += want.loop_event;
                    n_yoyo  += want.yoyo_event;
                    n_done  += want.done_event;
                end
            end
            if ((in_vld && in_if.ready) || (out_if.valid && out_rdy)) idle_cyc = 0;
            else idle_cyc++;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_phase(0);
        pending_cmds.push_back(mk_tick(16'd5, 1'b0));
        pending_cmds.push_back(mk_cmd(ppl_pkg::OP_RESTART));
        pending_cmds.push_back(mk_cmd(OP_RSVD6));
        pending_cmds.push_back(mk_cmd(OP_RSVD7));
        pending_cmds.push_back(mk_cmd(ppl_pkg::OP_START));
        pending_cmds.push_back(mk_tick(16'd1, 1'b0));
        pending_cmds.push_back(mk_tick(16'hFFFF, 1'b0));
        pending_cmds.push_back(mk_tick(16'd3, 1'b1));
        pending_cmds.push_back(mk_cmd(ppl_pkg::OP_PAUSE));
        pending_cmds.push_back(mk_tick(16'd2, 1'b0));
        pending_cmds.push_back(mk_cmd(ppl_pkg::OP_UNPAUSE));
        pending_cmds.push_back(mk_tick(16'd4, 1'b0));
        pending_cmds.push_back(mk_tick(16'hFFFF, 1'b0));
        pending_cmds.push_back(mk_tick(16'd5, 1'b0));
        pending_cmds.push_back(mk_tick(16'd3, 1'b0));
        pending_cmds.push_back(mk_tick(16'hFFFF, 1'b0));
        pending_cmds.push_back(mk_tick(16'd1, 1'b0));
        pending_cmds.push_back(mk_tick(16'd1, 1'b0));
        pending_cmds.push_back(mk_tick(16'hFFFF, 1'b0));
        pending_cmds.push_back(mk_tick(16'd9, 1'b0));
        pending_cmds.push_back(mk_tick(16'hFFFF, 1'b0));
        pending_cmds.push_back(mk_cmd(ppl_pkg::OP_RESTART));
        pending_cmds.push_back(mk_cmd(ppl_pkg::OP_START));
        pending_cmds.push_back(mk_cmd(ppl_pkg::OP_STOP));
        pending_cmds.push_back(mk_tick(16'd1, 1'b0));
        wait_idle();

        for (int ph = 1; ph < N_PHASES; ph++) begin
            load_phase(ph);
            queue_random(PHASE_ITEMS / 2);
            wait_idle();
            queue_random(PHASE_ITEMS / 2);
            wait_idle();
        end

        $display("%0d command beats, %0d results checked over %0d register settings",
                 n_in, n_out, N_PHASES);
        $display("moves %0d, loop events %0d, yoyo events %0d, completions %0d",
                 n_moved, n_loop, n_yoyo, n_done);
        if (errs == 0 && expected_status.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
